@@ design/cross_correlation_delay_estimator_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Immediate-cause and next-cycle property checks, removed for synthesis.
// ----------------------------------------------------------------------------
`ifndef CROSS_CORRELATION_DELAY_ESTIMATOR_MACROS_SVH
`define CROSS_CORRELATION_DELAY_ESTIMATOR_MACROS_SVH

`ifndef SYNTHESIS
`define CCDE_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define CCDE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CCDE_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define CCDE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

@@ design/ccde_pkg.sv @@
// ----------------------------------------------------------------------------
// ccde_pkg
// Shared constants, types and helpers of the delay estimator.
// ----------------------------------------------------------------------------
package ccde_pkg;

  localparam int WINDOW      = 256;
  localparam int SAMPLE_BITS = 16;
  localparam int TIME_W      = 32;
  localparam int LAG_W       = 9;
  localparam int D_W         = LAG_W + 1;
  localparam int ADDR_W      = $clog2(WINDOW);
  localparam int CNT_W       = $clog2(WINDOW + 1);
  localparam int KW          = ((CNT_W > D_W) ? CNT_W : D_W) + 2;
  localparam int SUM_W       = SAMPLE_BITS + CNT_W;
  localparam int CEN_W       = SUM_W + 1;
  localparam int PROD_W      = 2 * CEN_W;
  localparam int ACC_W       = PROD_W + CNT_W;
  localparam int DIVD_W      = TIME_W + SAMPLE_BITS;
  localparam int Q_W         = SAMPLE_BITS + 1;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_LAG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LAG = 1'b1;
  localparam logic signed [LAG_W-1:0] MIN_LAG_RESET = 9'sd0;
  localparam logic signed [LAG_W-1:0] MAX_LAG_RESET = 9'sd32;

  localparam logic [1:0] DIV_DX_STEP  = 2'd0;
  localparam logic [1:0] DIV_DX_START = 2'd1;
  localparam logic [1:0] DIV_DY_STEP  = 2'd2;
  localparam logic [1:0] DIV_DY_START = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_PUSH1, ST_RDNEW, ST_RDWAIT, ST_DIV, ST_DIVW, ST_INTERP,
    ST_SUM, ST_SUMW, ST_VAR, ST_LAG, ST_MAC, ST_MACW, ST_CMP, ST_DONE
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic capture;
    logic time_update;
    logic push_single;
    logic rd_newest;
    logic interp_setup;
    logic div_start;
    logic div_store;
    logic interp_step;
    logic sum_init;
    logic sum_step;
    logic lag_init;
    logic lag_skip;
    logic mac_init;
    logic mac_step;
    logic lag_compare;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic no_ref;
    logic advance;
    logic div_busy;
    logic div_last;
    logic interp_last;
    logic sum_last;
    logic pipe_busy;
    logic var_ok;
    logic lag_done;
    logic range_empty;
    logic mac_last;
    logic out_busy;
  } status_t;

  function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                 input logic [ADDR_W-1:0] off);
    logic [ADDR_W:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (ADDR_W+1)'(WINDOW)) begin
      s = s - (ADDR_W+1)'(WINDOW);
    end
    return s[ADDR_W-1:0];
  endfunction

endpackage

@@ design/ccde_in_if.sv @@
// ----------------------------------------------------------------------------
// ccde_in_if
// Sample channel: timestamp and one x/y pair per transfer.
// ----------------------------------------------------------------------------
interface ccde_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [ccde_pkg::TIME_W-1:0]             sample_time;
  logic signed [ccde_pkg::SAMPLE_BITS-1:0] x_sample;
  logic signed [ccde_pkg::SAMPLE_BITS-1:0] y_sample;

  modport source (output valid, sample_time, x_sample, y_sample, input ready);
  modport sink (input valid, sample_time, x_sample, y_sample, output ready);
endinterface

@@ design/ccde_out_if.sv @@
// ----------------------------------------------------------------------------
// ccde_out_if
// Result channel: lag estimate and update flag per transfer.
// ----------------------------------------------------------------------------
interface ccde_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ccde_pkg::LAG_W-1:0] delay_lag;
  logic                              estimate_updated;

  modport source (output valid, delay_lag, estimate_updated, input ready);
  modport sink (input valid, delay_lag, estimate_updated, output ready);
endinterface

@@ design/ccde_cfg_if.sv @@
// ----------------------------------------------------------------------------
// ccde_cfg_if
// Register write channel: index and data per transfer.
// ----------------------------------------------------------------------------
interface ccde_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ccde_pkg::CFG_IDX_W-1:0]    index;
  logic [ccde_pkg::LAG_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/ccde_div.sv @@
// ----------------------------------------------------------------------------
// ccde_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ccde_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ccde_pkg::DIVD_W-1:0]   dividend,
  input  logic [ccde_pkg::TIME_W-1:0]   divisor,
  output logic                          busy,
  output logic [ccde_pkg::DIVD_W-1:0]   quotient,
  output logic [ccde_pkg::TIME_W-1:0]   remainder
);
  localparam int CW = $clog2(ccde_pkg::DIVD_W);

  logic [CW-1:0]                 cnt;
  logic [ccde_pkg::TIME_W-1:0]   dsor;
  logic [ccde_pkg::TIME_W:0]     shifted;
  logic [ccde_pkg::TIME_W:0]     diff;
  logic                          ge;

  assign shifted = {remainder, quotient[ccde_pkg::DIVD_W-1]};
  assign ge      = shifted >= {1'b0, dsor};
  assign diff    = shifted - {1'b0, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CW'(ccde_pkg::DIVD_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dsor      <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[ccde_pkg::DIVD_W-2:0], ge};
      remainder <= ge ? diff[ccde_pkg::TIME_W-1:0] : shifted[ccde_pkg::TIME_W-1:0];
    end
  end
endmodule

@@ design/ccde_datapath.sv @@
// ----------------------------------------------------------------------------
// ccde_datapath
// Sample rings, interpolation, mean sums and lag correlation pipeline.
// ----------------------------------------------------------------------------
`include "cross_correlation_delay_estimator_macros.svh"

module ccde_datapath (
  input  logic                                    clk,
  input  logic                                    rst,
  input  ccde_pkg::cmd_t                          cmd,
  output ccde_pkg::status_t                       st,
  input  logic [ccde_pkg::TIME_W-1:0]             in_time,
  input  logic signed [ccde_pkg::SAMPLE_BITS-1:0] in_x,
  input  logic signed [ccde_pkg::SAMPLE_BITS-1:0] in_y,
  input  logic                                    cfg_valid,
  input  logic [ccde_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [ccde_pkg::LAG_W-1:0]              cfg_data,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [ccde_pkg::LAG_W-1:0]       out_lag,
  output logic                                    out_upd
);
  localparam int SB = ccde_pkg::SAMPLE_BITS;
  localparam int AW = ccde_pkg::ADDR_W;
  localparam int CW = ccde_pkg::CNT_W;
  localparam int TW = ccde_pkg::TIME_W;
  localparam int KW = ccde_pkg::KW;
  localparam int BW = CW + 1;

  logic signed [SB-1:0] mem_x [ccde_pkg::WINDOW];
  logic signed [SB-1:0] mem_y [ccde_pkg::WINDOW];
  logic signed [SB-1:0] rd_x, rd_y;

  logic [TW-1:0]        t_in;
  logic signed [SB-1:0] x_in, y_in;
  logic [CW-1:0]        fill_count;
  logic [AW-1:0]        wp;
  logic [TW-1:0]        last_time;
  logic signed [ccde_pkg::LAG_W-1:0] best_lag, min_lag, max_lag;

  logic [TW-1:0]        gap, k_first, interp_k;
  logic signed [SB-1:0] px, py;
  logic                 dx_neg, dy_neg;
  logic [SB-1:0]        adx, ady;
  logic [ccde_pkg::Q_W-1:0] qx, qy, qdx, qdy;
  logic [TW-1:0]        rx, ry, rdx, rdy;
  logic [1:0]           div_sel;

  logic                 div_busy;
  logic [ccde_pkg::DIVD_W-1:0] div_dividend, div_quo;
  logic [TW-1:0]        div_rem;
  logic [SB-1:0]        div_a;

  logic [CW-1:0]        idx;
  logic signed [ccde_pkg::SUM_W-1:0] sx, sy;
  logic                 sum_first, var_x, var_y;
  logic signed [SB-1:0] first_x, first_y;
  logic                 sum_v, mac_v1, mac_v2, mac_v3;

  logic signed [ccde_pkg::D_W-1:0]   d;
  logic [CW-1:0]                     mac_k;
  logic signed [ccde_pkg::CEN_W-1:0] cx, cy;
  logic signed [ccde_pkg::PROD_W-1:0] prod;
  logic signed [ccde_pkg::ACC_W-1:0] acc, best_sum;
  logic signed [ccde_pkg::LAG_W-1:0] best;

  logic [TW-1:0]        gap_c, k0_c;
  logic [BW-1:0]        base_s;
  logic [AW-1:0]        base, newest, rd_addr_x, rd_addr_y, wr_addr;
  logic                 wr_en;
  logic signed [SB-1:0] wr_x, wr_y;
  logic signed [SB+1:0] vx_c, vy_c;
  logic signed [SB:0]   dxv, dyv;
  logic [TW:0]          rx_sum, ry_sum;
  logic signed [KW-1:0] n_s, ks_c, ke_c, j_c, k_s;
  logic signed [ccde_pkg::CEN_W-1:0] n_c;

  // ring addressing
  assign base_s = BW'(wp) + BW'(ccde_pkg::WINDOW) - BW'(fill_count);
  assign base   = (base_s >= BW'(ccde_pkg::WINDOW)) ?
                  AW'(base_s - BW'(ccde_pkg::WINDOW)) : AW'(base_s);
  assign newest = (wp == '0) ? AW'(ccde_pkg::WINDOW - 1) : wp - 1'b1;

  assign gap_c = t_in - last_time;
  assign k0_c  = (gap_c > TW'(ccde_pkg::WINDOW)) ?
                 gap_c - TW'(ccde_pkg::WINDOW) + 1'b1 : TW'(1);

  // lag window
  assign n_s  = KW'($signed({1'b0, fill_count}));
  assign ks_c = (d < 0) ? -KW'(d) : '0;
  assign ke_c = (d < 0) ? n_s : n_s - KW'(d);
  assign k_s  = KW'($signed({1'b0, mac_k}));
  assign j_c  = k_s + KW'(d);

  always_comb begin
    if (cmd.rd_newest) begin
      rd_addr_x = newest;
      rd_addr_y = newest;
    end else if (cmd.sum_step) begin
      rd_addr_x = ccde_pkg::ring_add(base, idx[AW-1:0]);
      rd_addr_y = ccde_pkg::ring_add(base, idx[AW-1:0]);
    end else begin
      rd_addr_x = ccde_pkg::ring_add(base, mac_k[AW-1:0]);
      rd_addr_y = ccde_pkg::ring_add(base, j_c[AW-1:0]);
    end
  end

  // interpolated point
  assign vx_c = (SB+2)'(px) + (dx_neg ? -(SB+2)'({1'b0, qx}) : (SB+2)'({1'b0, qx}));
  assign vy_c = (SB+2)'(py) + (dy_neg ? -(SB+2)'({1'b0, qy}) : (SB+2)'({1'b0, qy}));
  assign rx_sum = {1'b0, rx} + {1'b0, rdx};
  assign ry_sum = {1'b0, ry} + {1'b0, rdy};

  assign wr_en   = cmd.push_single | cmd.interp_step;
  assign wr_addr = wp;
  assign wr_x    = cmd.push_single ? x_in : vx_c[SB-1:0];
  assign wr_y    = cmd.push_single ? y_in : vy_c[SB-1:0];

  assign dxv = (SB+1)'(x_in) - (SB+1)'(rd_x);
  assign dyv = (SB+1)'(y_in) - (SB+1)'(rd_y);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= wr_x;
      mem_y[wr_addr] <= wr_y;
    end
    rd_x <= mem_x[rd_addr_x];
    rd_y <= mem_y[rd_addr_y];
  end

  // divider
  assign div_a        = div_sel[1] ? ady : adx;
  assign div_dividend = div_sel[0] ?
                        ccde_pkg::DIVD_W'(k_first) * ccde_pkg::DIVD_W'(div_a)
                                   : ccde_pkg::DIVD_W'(div_a);

  ccde_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (gap),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      wp         <= '0;
      last_time  <= '0;
      best_lag   <= '0;
      min_lag    <= ccde_pkg::MIN_LAG_RESET;
      max_lag    <= ccde_pkg::MAX_LAG_RESET;
      out_valid  <= 1'b0;
      sum_v      <= 1'b0;
      mac_v1     <= 1'b0;
      mac_v2     <= 1'b0;
      mac_v3     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          ccde_pkg::REG_MIN_LAG: min_lag <= $signed(cfg_data);
          ccde_pkg::REG_MAX_LAG: max_lag <= $signed(cfg_data);
          default: ;
        endcase
      end
      if (cmd.time_update) begin
        last_time <= t_in;
      end
      if (wr_en) begin
        wp <= (wp == AW'(ccde_pkg::WINDOW - 1)) ? '0 : wp + 1'b1;
        if (fill_count < CW'(ccde_pkg::WINDOW)) begin
          fill_count <= fill_count + 1'b1;
        end
      end
      sum_v  <= cmd.sum_step;
      mac_v1 <= cmd.mac_step;
      mac_v2 <= mac_v1;
      mac_v3 <= mac_v2;
      if (cmd.publish) begin
        out_valid <= 1'b1;
        if (var_x && var_y) begin
          best_lag <= best;
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      t_in <= in_time;
      x_in <= in_x;
      y_in <= in_y;
    end
    if (cmd.time_update) begin
      gap      <= gap_c;
      k_first  <= k0_c;
      interp_k <= k0_c;
    end
    if (cmd.interp_setup) begin
      px      <= rd_x;
      py      <= rd_y;
      dx_neg  <= dxv[SB];
      dy_neg  <= dyv[SB];
      adx     <= dxv[SB] ? SB'(-dxv) : SB'(dxv);
      ady     <= dyv[SB] ? SB'(-dyv) : SB'(dyv);
      div_sel <= ccde_pkg::DIV_DX_STEP;
    end
    if (cmd.div_store) begin
      div_sel <= div_sel + 1'b1;
      case (div_sel)
        ccde_pkg::DIV_DX_STEP: begin
          qdx <= div_quo[ccde_pkg::Q_W-1:0];
          rdx <= div_rem;
        end
        ccde_pkg::DIV_DX_START: begin
          qx <= div_quo[ccde_pkg::Q_W-1:0];
          rx <= div_rem;
        end
        ccde_pkg::DIV_DY_STEP: begin
          qdy <= div_quo[ccde_pkg::Q_W-1:0];
          rdy <= div_rem;
        end
        default: begin
          qy <= div_quo[ccde_pkg::Q_W-1:0];
          ry <= div_rem;
        end
      endcase
    end
    if (cmd.interp_step) begin
      interp_k <= interp_k + 1'b1;
      if (rx_sum >= {1'b0, gap}) begin
        qx <= qx + qdx + 1'b1;
        rx <= TW'(rx_sum - {1'b0, gap});
      end else begin
        qx <= qx + qdx;
        rx <= rx_sum[TW-1:0];
      end
      if (ry_sum >= {1'b0, gap}) begin
        qy <= qy + qdy + 1'b1;
        ry <= TW'(ry_sum - {1'b0, gap});
      end else begin
        qy <= qy + qdy;
        ry <= ry_sum[TW-1:0];
      end
    end
    if (cmd.sum_init) begin
      idx       <= '0;
      sx        <= '0;
      sy        <= '0;
      sum_first <= 1'b1;
      var_x     <= 1'b0;
      var_y     <= 1'b0;
    end
    if (cmd.sum_step) begin
      idx <= idx + 1'b1;
    end
    if (sum_v) begin
      sx <= sx + ccde_pkg::SUM_W'(rd_x);
      sy <= sy + ccde_pkg::SUM_W'(rd_y);
      if (sum_first) begin
        first_x   <= rd_x;
        first_y   <= rd_y;
        sum_first <= 1'b0;
      end else begin
        if (rd_x != first_x) var_x <= 1'b1;
        if (rd_y != first_y) var_y <= 1'b1;
      end
    end
    if (cmd.lag_init) begin
      d        <= ccde_pkg::D_W'(min_lag);
      best     <= '0;
      best_sum <= '0;
    end
    if (cmd.lag_skip) begin
      d <= d + 1'b1;
    end
    if (cmd.lag_compare) begin
      d <= d + 1'b1;
      if (acc > best_sum) begin
        best_sum <= acc;
        best     <= d[ccde_pkg::LAG_W-1:0];
      end
    end
    if (cmd.mac_init) begin
      mac_k <= CW'(ks_c);
    end
    if (cmd.mac_step) begin
      mac_k <= mac_k + 1'b1;
    end
    cx   <= n_c * ccde_pkg::CEN_W'(rd_x) - ccde_pkg::CEN_W'(sx);
    cy   <= n_c * ccde_pkg::CEN_W'(rd_y) - ccde_pkg::CEN_W'(sy);
    prod <= ccde_pkg::PROD_W'(cx) * ccde_pkg::PROD_W'(cy);
    if (cmd.mac_init) begin
      acc <= '0;
    end else if (mac_v3) begin
      acc <= acc + ccde_pkg::ACC_W'(prod);
    end
    if (cmd.publish) begin
      out_lag <= (var_x && var_y) ? best : best_lag;
      out_upd <= var_x && var_y;
    end
  end

  assign n_c = ccde_pkg::CEN_W'($signed({1'b0, fill_count}));

  assign st.no_ref      = (last_time == '0) || (fill_count == '0);
  assign st.advance     = t_in > last_time;
  assign st.div_busy    = div_busy;
  assign st.div_last    = div_sel == ccde_pkg::DIV_DY_START;
  assign st.interp_last = interp_k == gap;
  assign st.sum_last    = idx == fill_count - 1'b1;
  assign st.pipe_busy   = sum_v | mac_v1 | mac_v2 | mac_v3;
  assign st.var_ok      = var_x && var_y;
  assign st.lag_done    = KW'(d) > KW'(max_lag);
  assign st.range_empty = ks_c >= ke_c;
  assign st.mac_last    = k_s == ke_c - 1'b1;
  assign st.out_busy    = out_valid && !out_ready;

  `CCDE_ASSERT_IMPL(a_fill_bound, clk, rst, 1'b1, fill_count <= CW'(ccde_pkg::WINDOW), "fill over window")
  `CCDE_ASSERT_IMPL(a_pub_free, clk, rst, cmd.publish, !out_valid || out_ready, "result overwritten")
  `CCDE_ASSERT_IMPL(a_cmp_drained, clk, rst, cmd.lag_compare, !st.pipe_busy, "compare before drain")
  `CCDE_ASSERT_NEXT(a_div_runs, clk, rst, cmd.div_start, div_busy, "divider did not start")
endmodule

@@ design/ccde_ctrl.sv @@
// ----------------------------------------------------------------------------
// ccde_ctrl
// Sequencer: resample, sum, then sweep lags through the MAC pipeline.
// ----------------------------------------------------------------------------
module ccde_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  ccde_pkg::status_t st,
  output ccde_pkg::cmd_t    cmd
);
  ccde_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ccde_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ccde_pkg::ST_IDLE:   if (in_valid) state_next = ccde_pkg::ST_CHECK;
      ccde_pkg::ST_CHECK: begin
        if (st.no_ref) state_next = ccde_pkg::ST_PUSH1;
        else if (st.advance) state_next = ccde_pkg::ST_RDNEW;
        else state_next = ccde_pkg::ST_SUM;
      end
      ccde_pkg::ST_PUSH1:  state_next = ccde_pkg::ST_SUM;
      ccde_pkg::ST_RDNEW:  state_next = ccde_pkg::ST_RDWAIT;
      ccde_pkg::ST_RDWAIT: state_next = ccde_pkg::ST_DIV;
      ccde_pkg::ST_DIV:    state_next = ccde_pkg::ST_DIVW;
      ccde_pkg::ST_DIVW: begin
        if (!st.div_busy) begin
          state_next = st.div_last ? ccde_pkg::ST_INTERP : ccde_pkg::ST_DIV;
        end
      end
      ccde_pkg::ST_INTERP: if (st.interp_last) state_next = ccde_pkg::ST_SUM;
      ccde_pkg::ST_SUM:    if (st.sum_last) state_next = ccde_pkg::ST_SUMW;
      ccde_pkg::ST_SUMW:   if (!st.pipe_busy) state_next = ccde_pkg::ST_VAR;
      ccde_pkg::ST_VAR: begin
        state_next = st.var_ok ? ccde_pkg::ST_LAG : ccde_pkg::ST_DONE;
      end
      ccde_pkg::ST_LAG: begin
        if (st.lag_done) state_next = ccde_pkg::ST_DONE;
        else if (!st.range_empty) state_next = ccde_pkg::ST_MAC;
      end
      ccde_pkg::ST_MAC:    if (st.mac_last) state_next = ccde_pkg::ST_MACW;
      ccde_pkg::ST_MACW:   if (!st.pipe_busy) state_next = ccde_pkg::ST_CMP;
      ccde_pkg::ST_CMP:    state_next = ccde_pkg::ST_LAG;
      ccde_pkg::ST_DONE:   if (!st.out_busy) state_next = ccde_pkg::ST_IDLE;
      default:             state_next = ccde_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ccde_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.capture  = in_valid;
      end
      ccde_pkg::ST_CHECK: begin
        cmd.time_update = 1'b1;
        cmd.sum_init    = !st.no_ref && !st.advance;
      end
      ccde_pkg::ST_PUSH1: begin
        cmd.push_single = 1'b1;
        cmd.sum_init    = 1'b1;
      end
      ccde_pkg::ST_RDNEW:  cmd.rd_newest = 1'b1;
      ccde_pkg::ST_RDWAIT: cmd.interp_setup = 1'b1;
      ccde_pkg::ST_DIV:    cmd.div_start = 1'b1;
      ccde_pkg::ST_DIVW:   cmd.div_store = !st.div_busy;
      ccde_pkg::ST_INTERP: begin
        cmd.interp_step = 1'b1;
        cmd.sum_init    = st.interp_last;
      end
      ccde_pkg::ST_SUM:    cmd.sum_step = 1'b1;
      ccde_pkg::ST_SUMW:   ;
      ccde_pkg::ST_VAR:    cmd.lag_init = st.var_ok;
      ccde_pkg::ST_LAG: begin
        cmd.lag_skip = !st.lag_done && st.range_empty;
        cmd.mac_init = !st.lag_done && !st.range_empty;
      end
      ccde_pkg::ST_MAC:    cmd.mac_step = 1'b1;
      ccde_pkg::ST_MACW:   ;
      ccde_pkg::ST_CMP:    cmd.lag_compare = 1'b1;
      ccde_pkg::ST_DONE:   cmd.publish = !st.out_busy;
      default: ;
    endcase
  end
endmodule

@@ design/cross_correlation_delay_estimator.sv @@
// ----------------------------------------------------------------------------
// cross_correlation_delay_estimator
// Time-delay estimate between two sampled signals by cross-correlation.
// ----------------------------------------------------------------------------
// Each sample transfer is resampled onto the tick grid (up to WINDOW points,
// written one per cycle, after four divisions when interpolating), summed
// over the window, then each lag from min_lag to max_lag is swept through a
// single multiply-accumulate pipeline fed by one read port per sample ring.
// The window holds 256 entries and the lag range resets to 0..32. One item
// is processed at a time; the next sample is taken while the previous result
// waits in the output register.
module cross_correlation_delay_estimator (
  input  logic       clk,
  input  logic       rst,
  ccde_in_if.sink    sample,
  ccde_out_if.source result,
  ccde_cfg_if.sink   cfg
);
  ccde_pkg::cmd_t    cmd;
  ccde_pkg::status_t st;

  assign sample.ready = cmd.in_ready;
  assign cfg.ready    = 1'b1;

  ccde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .st       (st),
    .cmd      (cmd)
  );

  ccde_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_time   (sample.sample_time),
    .in_x      (sample.x_sample),
    .in_y      (sample.y_sample),
    .cfg_valid (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_lag   (result.delay_lag),
    .out_upd   (result.estimate_updated)
  );
endmodule
